[hw/rtl/tpg_pkg.sv]
`default_nettype none
package tpg_pkg;

	localparam int SampleBits   = 24;
	localparam int IndexBits    = 48;
	localparam int CoefFraction = 16;
	localparam int MaxSteps     = 64;
	localparam int DivBits      = 7;
	localparam int StepBits     = 6;
	localparam int LenBits      = 40;
	localparam int LenFracBits  = 8;
	localparam int NumBits      = IndexBits + LenFracBits;
	localparam int CntBits      = 6;
	localparam int PatternBits  = 64;
	localparam int LevelBits    = 17;
	localparam int CoefBits     = 16;
	localparam int CfgIndexBits = 3;
	localparam int CfgDataBits  = 64;
	localparam int InDataBits   = 2 * SampleBits + IndexBits;
	localparam int OutDataBits  = 2 * SampleBits;

	localparam logic [LevelBits-1:0] OneLevel = LevelBits'(1 << CoefFraction);
	localparam logic [LenBits-1:0]   MinLen   = LenBits'(1 << LenFracBits);
	localparam logic [DivBits-1:0]   MaxDiv   = DivBits'(MaxSteps);

	typedef enum logic [CfgIndexBits-1:0] {
		REG_DIVISION,
		REG_STEP_LENGTH,
		REG_PATTERN,
		REG_GATE_FLOOR,
		REG_GATE_COEF,
		REG_HP_COEF,
		REG_WET,
		REG_MONO
	} cfg_reg_t;

	// settings after clamping, as the datapath uses them
	typedef struct packed {
		logic [DivBits-1:0]     division;
		logic [LenBits-1:0]     step_length;
		logic [PatternBits-1:0] pattern;
		logic [LevelBits-1:0]   gate_floor;
		logic [CoefBits-1:0]    gate_coef;
		logic [CoefBits-1:0]    hp_coef;
		logic [LevelBits-1:0]   wet;
		logic                   mono;
	} cfg_t;

	typedef struct packed {
		logic signed [SampleBits-1:0] xl;
		logic signed [SampleBits-1:0] xr;
		logic                         open;
	} item_t;

	// round to nearest, ties up: floor((v + half) / 2^CoefFraction)
	function automatic logic signed [47:0] rnd(input logic signed [47:0] v);
		logic signed [47:0] h;
		h = 48'sd1 <<< (CoefFraction - 1);
		return (v + h) >>> CoefFraction;
	endfunction

	function automatic logic signed [SampleBits-1:0] sat(input logic signed [47:0] v);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (SampleBits - 1)) - 48'sd1;
		lo = -(48'sd1 <<< (SampleBits - 1));
		if (v > hi) begin
			return hi[SampleBits-1:0];
		end else if (v < lo) begin
			return lo[SampleBits-1:0];
		end
		return v[SampleBits-1:0];
	endfunction

endpackage
`default_nettype wire

[hw/rtl/tempo_pattern_gate_highpass.sv]
// Stereo tempo-synced pattern gate with a high-pass and wet/dry mix.
// Frames enter on s_* and leave on m_*, one result per frame, in order. The
// front end finds the pattern step with a bit-serial divider, one quotient
// bit per cycle, and takes no new frame until that step is pushed on; the
// back end runs the gate smoother, both high-passes and the mix on one
// shared multiplier and takes no new frame until its result is loaded. A
// two-entry queue sits between them and the output beat is registered. The
// user must write registers through cfg_we/cfg_index/cfg_data only while no
// frame is in flight; the block itself does not enforce this.
`default_nettype none
module tempo_pattern_gate_highpass (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [tpg_pkg::CfgIndexBits-1:0]      cfg_index,
	input  wire logic [tpg_pkg::CfgDataBits-1:0]       cfg_data,
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// sample_left[23:0], sample_right[47:24], sample_index[95:48]
	input  wire logic [tpg_pkg::InDataBits-1:0]        s_tdata,
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// out_left[23:0], out_right[47:24]
	output logic [tpg_pkg::OutDataBits-1:0]            m_tdata
);

	logic [tpg_pkg::DivBits-1:0]     division_q;
	logic [tpg_pkg::LenBits-1:0]     step_length_q;
	logic [tpg_pkg::PatternBits-1:0] pattern_q;
	logic [tpg_pkg::LevelBits-1:0]   gate_floor_q;
	logic [tpg_pkg::CoefBits-1:0]    gate_coef_q;
	logic [tpg_pkg::CoefBits-1:0]    hp_coef_q;
	logic [tpg_pkg::LevelBits-1:0]   wet_q;
	logic                            mono_q;

	tpg_pkg::cfg_t  cfg;
	logic           q_in_valid;
	logic           q_in_ready;
	tpg_pkg::item_t q_in_item;
	logic           q_out_valid;
	logic           q_out_ready;
	tpg_pkg::item_t q_out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			division_q    <= tpg_pkg::DivBits'(16);
			step_length_q <= tpg_pkg::LenBits'(705600);
			pattern_q     <= '1;
			gate_floor_q  <= tpg_pkg::OneLevel;
			gate_coef_q   <= tpg_pkg::CoefBits'(650);
			hp_coef_q     <= tpg_pkg::CoefBits'(65303);
			wet_q         <= tpg_pkg::OneLevel;
			mono_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (tpg_pkg::cfg_reg_t'(cfg_index))
				tpg_pkg::REG_DIVISION:    division_q    <= cfg_data[tpg_pkg::DivBits-1:0];
				tpg_pkg::REG_STEP_LENGTH: step_length_q <= cfg_data[tpg_pkg::LenBits-1:0];
				tpg_pkg::REG_PATTERN:     pattern_q     <= cfg_data;
				tpg_pkg::REG_GATE_FLOOR:  gate_floor_q  <= cfg_data[tpg_pkg::LevelBits-1:0];
				tpg_pkg::REG_GATE_COEF:   gate_coef_q   <= cfg_data[tpg_pkg::CoefBits-1:0];
				tpg_pkg::REG_HP_COEF:     hp_coef_q     <= cfg_data[tpg_pkg::CoefBits-1:0];
				tpg_pkg::REG_WET:         wet_q         <= cfg_data[tpg_pkg::LevelBits-1:0];
				tpg_pkg::REG_MONO:        mono_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp settings to their usable ranges
	always_comb begin
		if (division_q == '0) begin
			cfg.division = tpg_pkg::DivBits'(1);
		end else if (division_q > tpg_pkg::MaxDiv) begin
			cfg.division = tpg_pkg::MaxDiv;
		end else begin
			cfg.division = division_q;
		end
		cfg.step_length = (step_length_q < tpg_pkg::MinLen) ? tpg_pkg::MinLen : step_length_q;
		cfg.pattern     = pattern_q;
		cfg.gate_floor  = (gate_floor_q > tpg_pkg::OneLevel) ? tpg_pkg::OneLevel : gate_floor_q;
		cfg.gate_coef   = gate_coef_q;
		cfg.hp_coef     = hp_coef_q;
		cfg.wet         = (wet_q > tpg_pkg::OneLevel) ? tpg_pkg::OneLevel : wet_q;
		cfg.mono        = mono_q;
	end

	tpg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (q_in_valid),
		.q_ready  (q_in_ready),
		.q_item   (q_in_item)
	);

	tpg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_in_valid),
		.in_ready  (q_in_ready),
		.in_item   (q_in_item),
		.out_valid (q_out_valid),
		.out_ready (q_out_ready),
		.out_item  (q_out_item)
	);

	tpg_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_valid  (q_out_valid),
		.q_ready  (q_out_ready),
		.q_item   (q_out_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

[hw/rtl/tpg_front.sv]
`default_nettype none
module tpg_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tpg_pkg::cfg_t                      cfg,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [tpg_pkg::InDataBits-1:0]     s_tdata,
	output logic                                    q_valid,
	input  wire logic                               q_ready,
	output tpg_pkg::item_t                          q_item
);

	typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

	fstate_t                          state_q;
	logic [tpg_pkg::CntBits-1:0]      cnt_q;
	logic [tpg_pkg::NumBits-1:0]      num_q;
	logic [tpg_pkg::LenBits-1:0]      rem_q;
	logic [tpg_pkg::StepBits-1:0]     mod_q;
	tpg_pkg::item_t                   item_q;

	logic [tpg_pkg::LenBits:0]        trial;
	logic                             qbit;
	logic [tpg_pkg::LenBits:0]        rem_next;
	logic [tpg_pkg::StepBits:0]       mod_trial;
	logic [tpg_pkg::StepBits:0]       mod_next;
	logic signed [tpg_pkg::SampleBits-1:0] in_l;
	logic signed [tpg_pkg::SampleBits-1:0] in_r;

	// restoring divide, one quotient bit per beat; the quotient is reduced
	// modulo division as its bits come out, MSB first
	always_comb begin
		trial     = {rem_q, num_q[tpg_pkg::NumBits-1]};
		qbit      = trial >= {1'b0, cfg.step_length};
		rem_next  = qbit ? trial - {1'b0, cfg.step_length} : trial;
		mod_trial = {mod_q, qbit};
		mod_next  = (mod_trial >= cfg.division) ? mod_trial - cfg.division : mod_trial;
	end

	assign in_l = s_tdata[tpg_pkg::SampleBits-1:0];
	assign in_r = s_tdata[2*tpg_pkg::SampleBits-1:tpg_pkg::SampleBits];

	assign s_tready = (state_q == F_IDLE);
	assign q_valid  = (state_q == F_PUSH);
	assign q_item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						state_q     <= F_DIV;
						cnt_q       <= '0;
						num_q       <= {s_tdata[tpg_pkg::InDataBits-1:2*tpg_pkg::SampleBits],
							{tpg_pkg::LenFracBits{1'b0}}};
						rem_q       <= '0;
						mod_q       <= '0;
						item_q.xl   <= in_l;
						item_q.xr   <= cfg.mono ? in_l : in_r;
						item_q.open <= 1'b0;
					end
				end
				F_DIV: begin
					rem_q <= rem_next[tpg_pkg::LenBits-1:0];
					mod_q <= mod_next[tpg_pkg::StepBits-1:0];
					num_q <= {num_q[tpg_pkg::NumBits-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tpg_pkg::CntBits'(tpg_pkg::NumBits - 1)) begin
						item_q.open <= cfg.pattern[mod_next[tpg_pkg::StepBits-1:0]];
						state_q     <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (q_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tpg_fifo.sv]
`default_nettype none
module tpg_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tpg_pkg::item_t in_item,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tpg_pkg::item_t      out_item
);

	tpg_pkg::item_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tpg_back.sv]
`default_nettype none
module tpg_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tpg_pkg::cfg_t                    cfg,
	input  wire logic                             q_valid,
	output logic                                  q_ready,
	input  wire tpg_pkg::item_t                   q_item,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [tpg_pkg::OutDataBits-1:0]       m_tdata
);

	localparam int SB = tpg_pkg::SampleBits;

	typedef enum logic [3:0] {
		B_IDLE, B_GMUL, B_GUPD, B_HMUL, B_HUPD, B_YMUL, B_YUPD,
		B_XMUL, B_XUPD, B_WMUL, B_WUPD, B_OUT
	} bstate_t;

	bstate_t                      state_q;
	logic                         ch_q;
	tpg_pkg::item_t               item_q;
	logic [tpg_pkg::LevelBits-1:0] gate_q;
	logic signed [SB-1:0]         in_l_q;
	logic signed [SB-1:0]         in_r_q;
	logic signed [SB-1:0]         hp_l_q;
	logic signed [SB-1:0]         hp_r_q;
	logic signed [26:0]           hg_q;
	logic signed [45:0]           acc_q;
	logic signed [45:0]           prod_q;
	logic signed [SB-1:0]         res_l_q;
	logic signed [SB-1:0]         res_r_q;
	logic                         m_tvalid_q;
	logic [tpg_pkg::OutDataBits-1:0] m_tdata_q;

	logic signed [SB-1:0]         x_sel;
	logic signed [SB-1:0]         in_sel;
	logic signed [SB-1:0]         hp_sel;
	logic [tpg_pkg::LevelBits-1:0] target;
	logic [tpg_pkg::LevelBits-1:0] dry;
	logic signed [17:0]           g_diff;
	logic signed [25:0]           hp_sum;
	logic signed [26:0]           mul_a;
	logic signed [18:0]           mul_b;
	logic signed [47:0]           r_prod;
	logic signed [47:0]           r_acc;
	logic signed [17:0]           g_new;
	logic signed [SB-1:0]         y_new;
	logic signed [SB-1:0]         res;

	assign x_sel  = ch_q ? item_q.xr : item_q.xl;
	assign in_sel = ch_q ? in_r_q : in_l_q;
	assign hp_sel = ch_q ? hp_r_q : hp_l_q;
	assign target = item_q.open ? tpg_pkg::OneLevel : cfg.gate_floor;
	assign dry    = tpg_pkg::OneLevel - cfg.wet;
	assign g_diff = $signed({1'b0, target}) - $signed({1'b0, gate_q});
	assign hp_sum = 26'(hp_sel) + 26'(x_sel) - 26'(in_sel);

	// one shared multiplier, operands picked by the sequencer
	always_comb begin
		unique case (state_q)
			B_GMUL: begin
				mul_a = 27'(g_diff);
				mul_b = $signed({3'b0, cfg.gate_coef});
			end
			B_HMUL: begin
				mul_a = 27'(hp_sum);
				mul_b = $signed({3'b0, cfg.hp_coef});
			end
			B_YMUL: begin
				mul_a = 27'(hp_sel);
				mul_b = $signed({2'b0, gate_q});
			end
			B_XMUL: begin
				mul_a = 27'(x_sel);
				mul_b = $signed({2'b0, dry});
			end
			B_WMUL: begin
				mul_a = hg_q;
				mul_b = $signed({2'b0, cfg.wet});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign r_prod = tpg_pkg::rnd(48'(prod_q));
	assign r_acc  = tpg_pkg::rnd(48'(acc_q) + 48'(prod_q));
	assign g_new  = $signed({1'b0, gate_q}) + $signed(r_prod[17:0]);
	assign y_new  = tpg_pkg::sat(r_prod);
	assign res    = tpg_pkg::sat(r_acc);

	assign q_ready  = (state_q == B_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			ch_q       <= 1'b0;
			gate_q     <= tpg_pkg::OneLevel;
			in_l_q     <= '0;
			in_r_q     <= '0;
			hp_l_q     <= '0;
			hp_r_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// B_OUT handles the beat itself when it loads the next one
			if (m_tvalid_q && m_tready && (state_q != B_OUT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						ch_q    <= 1'b0;
						state_q <= B_GMUL;
					end
				end
				B_GMUL: state_q <= B_GUPD;
				B_GUPD: begin
					gate_q  <= g_new[tpg_pkg::LevelBits-1:0];
					state_q <= B_HMUL;
				end
				B_HMUL: state_q <= B_HUPD;
				B_HUPD: begin
					if (ch_q) begin
						hp_r_q <= y_new;
						in_r_q <= x_sel;
					end else begin
						hp_l_q <= y_new;
						in_l_q <= x_sel;
					end
					state_q <= B_YMUL;
				end
				B_YMUL: state_q <= B_YUPD;
				B_YUPD: begin
					hg_q    <= r_prod[26:0];
					state_q <= B_XMUL;
				end
				B_XMUL: state_q <= B_XUPD;
				B_XUPD: begin
					acc_q   <= prod_q;
					state_q <= B_WMUL;
				end
				B_WMUL: state_q <= B_WUPD;
				B_WUPD: begin
					if (ch_q) begin
						res_r_q <= res;
						state_q <= B_OUT;
					end else begin
						res_l_q <= res;
						ch_q    <= 1'b1;
						state_q <= B_HMUL;
					end
				end
				B_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {res_r_q, res_l_q};
						m_tvalid_q <= 1'b1;
						state_q    <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hw/rtl/tpg_checker.sv]
`default_nettype none
module tpg_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [tpg_pkg::OutDataBits-1:0]    m_tdata
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	// the step divider keeps the front busy after taking a frame
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front took a frame while dividing");

	// no result can come out right behind a frame that was just taken
	a_no_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too soon after input");

endmodule

bind tempo_pattern_gate_highpass tpg_checker u_tpg_checker (.*);
`default_nettype wire

[tb/sv/tb_tempo_pattern_gate_highpass.sv]
`timescale 1ns / 1ps
`default_nettype none
module tb_tempo_pattern_gate_highpass;

	localparam longint ONE_Q16    = 65536;
	localparam longint SAMPLE_MAX = 8388607;
	localparam longint SAMPLE_MIN = -8388608;
	localparam int     CYCLE_LIMIT = 1000000;
	localparam int     DRAIN_CYCLES = 120;

	typedef enum logic {ROW_CFG, ROW_FRAME} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		tpg_pkg::cfg_reg_t     reg_sel;
		logic [63:0]           value;
		logic signed [23:0]    left;
		logic signed [23:0]    right;
		logic [47:0]           index;
		bit                    typed;
		logic signed [23:0]    want_left;
		logic signed [23:0]    want_right;
	} row_t;

	typedef struct {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} stereo_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [tpg_pkg::CfgIndexBits-1:0]    cfg_index;
	logic [tpg_pkg::CfgDataBits-1:0]     cfg_data;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [tpg_pkg::InDataBits-1:0]      s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [tpg_pkg::OutDataBits-1:0]     m_tdata;

	tempo_pattern_gate_highpass dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// predictor copy of the registers and state
	logic [6:0]  p_division;
	logic [39:0] p_step_len;
	logic [63:0] p_pattern;
	logic [16:0] p_floor;
	logic [15:0] p_gate_coef;
	logic [15:0] p_hp_coef;
	logic [16:0] p_wet;
	logic        p_mono;
	longint      gate_lvl, prev_in_l, prev_in_r, prev_hp_l, prev_hp_r;

	stereo_t pending_out[$];
	int      error_count;
	int      hold_request;
	int      burst_left;
	bit      gaps_on;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic longint round_q16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	function automatic longint clip_sample(input longint v);
		if (v > SAMPLE_MAX) begin
			return SAMPLE_MAX;
		end
		if (v < SAMPLE_MIN) begin
			return SAMPLE_MIN;
		end
		return v;
	endfunction

	function automatic longint mix_out(input longint x, input longint y, input longint wet);
		longint hg;
		hg = round_q16(y * gate_lvl);
		return clip_sample(round_q16(x * (ONE_Q16 - wet) + hg * wet));
	endfunction

	function automatic stereo_t gate_frame(input logic signed [23:0] l,
			input logic signed [23:0] r, input logic [47:0] idx);
		stereo_t res;
		longint xl, xr, flo, target, wet, yl, yr;
		logic [63:0] pos, len, div, step;
		xl = longint'(l);
		xr = p_mono ? xl : longint'(r);
		pos = {16'd0, idx};
		len = (p_step_len < 40'd256) ? 64'd256 : {24'd0, p_step_len};
		div = (p_division == 7'd0) ? 64'd1 : {57'd0, p_division};
		if (div > 64'd64) begin
			div = 64'd64;
		end
		step = ((pos << 8) / len) % div;
		flo = longint'(p_floor);
		if (flo > ONE_Q16) begin
			flo = ONE_Q16;
		end
		target = p_pattern[step[5:0]] ? ONE_Q16 : flo;
		gate_lvl += round_q16(longint'(p_gate_coef) * (target - gate_lvl));
		yl = clip_sample(round_q16(longint'(p_hp_coef) * (prev_hp_l + xl - prev_in_l)));
		yr = clip_sample(round_q16(longint'(p_hp_coef) * (prev_hp_r + xr - prev_in_r)));
		prev_in_l = xl;
		prev_hp_l = yl;
		prev_in_r = xr;
		prev_hp_r = yr;
		wet = longint'(p_wet);
		if (wet > ONE_Q16) begin
			wet = ONE_Q16;
		end
		res.left = 24'(mix_out(xl, yl, wet));
		res.right = 24'(mix_out(xr, yr, wet));
		return res;
	endfunction

	task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $realtime);
		error_count++;
	endtask

	task automatic write_reg(input tpg_pkg::cfg_reg_t sel, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (sel)
			tpg_pkg::REG_DIVISION:    p_division = value[6:0];
			tpg_pkg::REG_STEP_LENGTH: p_step_len = value[39:0];
			tpg_pkg::REG_PATTERN:     p_pattern = value;
			tpg_pkg::REG_GATE_FLOOR:  p_floor = value[16:0];
			tpg_pkg::REG_GATE_COEF:   p_gate_coef = value[15:0];
			tpg_pkg::REG_HP_COEF:     p_hp_coef = value[15:0];
			tpg_pkg::REG_WET:         p_wet = value[16:0];
			default:                  p_mono = value[0];
		endcase
	endtask

	// offer one beat; returns after it is accepted, valid left high
	task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
			input logic [47:0] idx, input bit typed, input stereo_t want);
		stereo_t pred;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {idx, r, l};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		pred = gate_frame(l, r, idx);
		pending_out.push_back(typed ? want : pred);
	endtask

	task automatic pause_sender(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_idle();
		pause_sender(1);
		while (pending_out.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic burst_gap();
		if (!gaps_on) begin
			return;
		end
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(20, 0);
		pause_sender(($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) :
			$urandom_range(8, 1));
	endtask

	function automatic logic [63:0] pick_reg_value(input tpg_pkg::cfg_reg_t sel);
		int mode;
		mode = $urandom_range(5, 0);
		case (sel)
			tpg_pkg::REG_DIVISION:
				return (mode == 0) ? 64'(7'h7F) : (mode == 1) ? 64'd0 :
					64'($urandom_range(64, 1));
			tpg_pkg::REG_STEP_LENGTH:
				return (mode == 0) ? 64'h00FF_FFFF_FFFF :
					(mode == 1) ? 64'($urandom_range(255, 0)) :
					(mode == 2) ? {24'd0, 8'($urandom), $urandom} :
					64'($urandom_range(256 * 24, 256));
			tpg_pkg::REG_PATTERN:
				return (mode == 0) ? 64'd0 : (mode == 1) ? '1 : {$urandom, $urandom};
			tpg_pkg::REG_GATE_FLOOR:
				return (mode == 0) ? 64'h1FFFF : (mode == 1) ? 64'd65 :
					(mode == 2) ? 64'($urandom_range(64, 0)) :
					64'($urandom_range(65536, 65));
			tpg_pkg::REG_GATE_COEF, tpg_pkg::REG_HP_COEF:
				return (mode == 0) ? 64'hFFFF : (mode == 1) ? 64'd0 :
					(mode == 2) ? 64'd1 : 64'($urandom_range(65535, 1));
			tpg_pkg::REG_WET:
				return (mode == 0) ? 64'h1FFFF : (mode == 1) ? 64'd0 :
					(mode == 2) ? 64'd65536 : 64'($urandom_range(65536, 0));
			default:
				return 64'($urandom_range(1, 0));
		endcase
	endfunction

	function automatic logic signed [23:0] pick_sample();
		case ($urandom_range(7, 0))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return 24'($urandom_range(200, 0)) - 24'd100;
			default: return 24'($urandom);
		endcase
	endfunction

	// receiver: own stall pattern, plus a long hold when asked
	initial begin
		int hold_left;
		int mode_left;
		int mode;
		logic [7:0] stall_pat;
		stereo_t want;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		stall_pat = 8'b1011_0110;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(2, 0);
				mode_left = $urandom_range(300, 50);
			end
			mode_left--;
			stall_pat = {stall_pat[6:0], stall_pat[7]};
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(3, 0) != 0);
					default: m_tready <= stall_pat[0];
				endcase
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_out.size() == 0) begin
					$display("unexpected output beat at %0t", $realtime);
					error_count++;
				end else begin
					want = pending_out.pop_front();
					if (m_tdata[23:0] !== want.left) begin
						report("out_left", m_tdata[23:0], want.left);
					end
					if (m_tdata[47:24] !== want.right) begin
						report("out_right", m_tdata[47:24], want.right);
					end
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	row_t plan[] = '{
		// reset settings, a silent frame then full-scale frames
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b1, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h7FFFFF, 24'h800000,
			48'hFFFF_FFFF_FFFF, 1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h800000, 24'h7FFFFF, 48'd12345,
			1'b0, 24'sd0, 24'sd0},
		// fully dry: output is the input, with right taken from left in mono
		'{ROW_CFG, tpg_pkg::REG_WET, 64'd0, 24'sd0, 24'sd0, 48'd0, 1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h7FFFFF, 24'h800000, 48'd7,
			1'b1, 24'h7FFFFF, 24'h800000},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h800000, 24'h7FFFFF, 48'd8,
			1'b1, 24'h800000, 24'h7FFFFF},
		'{ROW_CFG, tpg_pkg::REG_MONO, 64'd1, 24'sd0, 24'sd0, 48'd0, 1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd100, -24'sd5, 48'd9,
			1'b1, 24'sd100, 24'sd100},
		// wet clamps to one, zero high-pass coefficient silences the wet path
		'{ROW_CFG, tpg_pkg::REG_MONO, 64'd0, 24'sd0, 24'sd0, 48'd0, 1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_WET, 64'h1FFFF, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_HP_COEF, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h7FFFFF, 24'h800000, 48'd10,
			1'b1, 24'sd0, 24'sd0},
		// full high-pass coefficient, short step, zero division, closed pattern, zero floor, fastest smoother
		'{ROW_CFG, tpg_pkg::REG_HP_COEF, 64'hFFFF, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_DIVISION, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_STEP_LENGTH, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_PATTERN, 64'h0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_FLOOR, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_COEF, 64'hFFFF, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		// high-pass overflow with large swings
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h800000, 24'h7FFFFF, 48'd1,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h7FFFFF, 24'h800000, 48'd2,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'h800000, 24'h7FFFFF, 48'd3,
			1'b0, 24'sd0, 24'sd0},
		// division above the step count, longest step, floor clamps, frozen gate
		'{ROW_CFG, tpg_pkg::REG_DIVISION, 64'h7F, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_STEP_LENGTH, 64'hFF_FFFF_FFFF, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_PATTERN, 64'hAAAA_AAAA_AAAA_AAAA, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_FLOOR, 64'h1FFFF, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_COEF, 64'd0, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd4000, -24'sd4000,
			48'hFFFF_FFFF_FFFF, 1'b0, 24'sd0, 24'sd0},
		// every step open/closed in turn, one-sample steps
		'{ROW_CFG, tpg_pkg::REG_DIVISION, 64'd64, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_STEP_LENGTH, 64'd256, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_FLOOR, 64'd65, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_GATE_COEF, 64'd30000, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_CFG, tpg_pkg::REG_WET, 64'd40000, 24'sd0, 24'sd0, 48'd0,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd300000, 24'sd1, 48'd63,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, -24'sd300000, 24'sd2, 48'd64,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd50000, 24'sd3, 48'd65,
			1'b0, 24'sd0, 24'sd0},
		'{ROW_FRAME, tpg_pkg::REG_DIVISION, 64'd0, 24'sd0, 24'sd4, 48'd66,
			1'b0, 24'sd0, 24'sd0}
	};

	initial begin
		stereo_t want;
		logic [47:0] idx;
		int frames;
		bit prev_cfg;
		error_count = 0;
		hold_request = 0;
		burst_left = 0;
		gaps_on = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		p_division = 7'd16;
		p_step_len = 40'd705600;
		p_pattern = '1;
		p_floor = 17'd65536;
		p_gate_coef = 16'd650;
		p_hp_coef = 16'd65303;
		p_wet = 17'd65536;
		p_mono = 1'b0;
		gate_lvl = ONE_Q16;
		prev_in_l = 0;
		prev_in_r = 0;
		prev_hp_l = 0;
		prev_hp_r = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		prev_cfg = 1'b1;
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (!prev_cfg) begin
					wait_idle();
				end
				write_reg(plan[i].reg_sel, plan[i].value);
				prev_cfg = 1'b1;
			end else begin
				want.left = plan[i].want_left;
				want.right = plan[i].want_right;
				send_frame(plan[i].left, plan[i].right, plan[i].index, plan[i].typed, want);
				prev_cfg = 1'b0;
			end
		end

		// random phases: fresh settings, then a run of frames along the timeline
		for (int phase = 0; phase < 7; phase++) begin
			wait_idle();
			for (int r = 0; r < 8; r++) begin
				write_reg(tpg_pkg::cfg_reg_t'(r), pick_reg_value(tpg_pkg::cfg_reg_t'(r)));
			end
			gaps_on = (phase != 3);
			if (phase == 2) begin
				hold_request = 700;
			end
			idx = 48'({$urandom, $urandom});
			if ($urandom_range(3, 0) == 0) begin
				idx = 48'hFFFF_FFFF_FFFF - 48'd200;
			end
			frames = 150;
			for (int n = 0; n < frames; n++) begin
				send_frame(pick_sample(), pick_sample(), idx, 1'b0, want);
				idx += ($urandom_range(15, 0) == 0) ? 48'($urandom) : 48'd1;
				burst_gap();
			end
		end

		wait_idle();
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/tpg_pkg.sv
hw/rtl/tpg_front.sv
hw/rtl/tpg_fifo.sv
hw/rtl/tpg_back.sv
hw/rtl/tempo_pattern_gate_highpass.sv
hw/rtl/tpg_checker.sv
tb/sv/tb_tempo_pattern_gate_highpass.sv
